// File: rtl/lfpd_pkg.sv
// Shared types, widths and constants for the line-follow PD steering block.
// No dependencies; every other file refers to it by scoped names.
package lfpd_pkg;

    localparam int SENSOR_W   = 8;
    localparam int TIME_W     = 32;
    localparam int PWM_W      = 8;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Only eight sensor bits exist, so |weight| <= 7 and |sum| <= 28.
    localparam int SUM_W   = 6;
    localparam int COUNT_W = 4;
    localparam int ERR_W   = 12;  // |error| <= 7 * 256
    localparam int DE_W    = ERR_W + 1;
    localparam int DVD_W   = 22;  // |delta error| * 1000 < 2^22
    localparam int DER_W   = DVD_W + 1;
    localparam int PROD_W  = GAIN_W + 1 + DER_W;
    localparam int CORR_W  = PROD_W + 1;
    localparam int V_W     = CORR_W + 1;
    localparam int FRAC_W  = 16;

    localparam int DerivScale = 1000;
    localparam logic [PWM_W-1:0] PWM_MAX = 8'd255;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd8960;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd0;
    localparam logic [PWM_W-1:0]  BASE_SPEED_RST = 8'd80;
    localparam logic [PWM_W-1:0]  LOST_LEFT_RST  = 8'd0;
    localparam logic [PWM_W-1:0]  LOST_RIGHT_RST = 8'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_DERIV_GAIN = 3'd1,
        REG_BASE_SPEED = 3'd2,
        REG_LOST_LEFT  = 3'd3,
        REG_LOST_RIGHT = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] deriv_gain;
        logic [PWM_W-1:0]  base_speed;
        logic [PWM_W-1:0]  lost_left_pwm;
        logic [PWM_W-1:0]  lost_right_pwm;
    } cfg_t;

    typedef struct packed {
        logic load;       // capture input request
        logic err_start;  // launch |sum|*256 / count
        logic take_err;
        logic der_start;  // launch |de|*1000 / dt
        logic der_zero;
        logic take_der;
        logic mul_p;
        logic mul_d;
        logic add;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic lost;
        logic dt_zero;
        logic div_done;
        logic out_free;
    } status_t;

    // Q.16 value -> duty, truncated and clamped; negatives give zero.
    function automatic logic [PWM_W-1:0] duty_of(input logic signed [V_W-1:0] v);
        logic [PWM_W-1:0] d;
        d = PWM_MAX;
        if (v < 0)
        begin
            d = '0;
        end
        else if (v[V_W-1:FRAC_W] <= (V_W-FRAC_W)'(PWM_MAX))
        begin
            d = v[FRAC_W+PWM_W-1:FRAC_W];
        end
        return d;
    endfunction

endpackage

// File: rtl/lfpd_if.sv
// Valid/ready channels for sensor requests and steering results.
// Depends on lfpd_pkg for field widths.
interface lfpd_in_if;
    logic                          valid;
    logic                          ready;
    logic [lfpd_pkg::SENSOR_W-1:0] sensor_bits;
    logic [lfpd_pkg::TIME_W-1:0]   now_ms;

    modport source (output valid, sensor_bits, now_ms, input ready);
    modport sink   (input valid, sensor_bits, now_ms, output ready);
endinterface

interface lfpd_out_if;
    logic                       valid;
    logic                       ready;
    logic [lfpd_pkg::PWM_W-1:0] left_pwm;
    logic [lfpd_pkg::PWM_W-1:0] right_pwm;
    logic                       line_lost;

    modport source (output valid, left_pwm, right_pwm, line_lost, input ready);
    modport sink   (input valid, left_pwm, right_pwm, line_lost, output ready);
endinterface

// File: rtl/line_follow_pd_steering.sv
// Line-follow PD steering: sensor pattern + timestamp in, left/right duty out.
// Per request: when the line is seen, the 22-step divider runs once for the error, then
// again for the derivative unless no time has elapsed; a lost line skips both divides.
// One request in flight, one result in the output reg; in_ready is low until the result loads.
// Reset clears the controller, output valid, last error/time and loads config defaults.
// Depends on lfpd_pkg, lfpd_if, lfpd_ctrl, lfpd_datapath.
module line_follow_pd_steering
#(
    parameter int SENSOR_COUNT = 8
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    lfpd_in_if.sink                           sensor,
    lfpd_out_if.source                        drive,
    input  logic                              wr_en,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0]   wr_data
);

    lfpd_pkg::cfg_t    cfg_reg;
    lfpd_pkg::cmd_t    cmd;
    lfpd_pkg::status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain      <= lfpd_pkg::PROP_GAIN_RST;
            cfg_reg.deriv_gain     <= lfpd_pkg::DERIV_GAIN_RST;
            cfg_reg.base_speed     <= lfpd_pkg::BASE_SPEED_RST;
            cfg_reg.lost_left_pwm  <= lfpd_pkg::LOST_LEFT_RST;
            cfg_reg.lost_right_pwm <= lfpd_pkg::LOST_RIGHT_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                lfpd_pkg::REG_PROP_GAIN:  cfg_reg.prop_gain      <= wr_data;
                lfpd_pkg::REG_DERIV_GAIN: cfg_reg.deriv_gain     <= wr_data;
                lfpd_pkg::REG_BASE_SPEED: cfg_reg.base_speed     <= wr_data[lfpd_pkg::PWM_W-1:0];
                lfpd_pkg::REG_LOST_LEFT:  cfg_reg.lost_left_pwm  <= wr_data[lfpd_pkg::PWM_W-1:0];
                lfpd_pkg::REG_LOST_RIGHT: cfg_reg.lost_right_pwm <= wr_data[lfpd_pkg::PWM_W-1:0];
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    lfpd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sensor.valid),
        .in_ready (sensor.ready),
        .status   (status),
        .cmd      (cmd)
    );

    lfpd_datapath
    #(
        .SENSOR_COUNT (SENSOR_COUNT)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .status    (status),
        .in_bits   (sensor.sensor_bits),
        .in_now    (sensor.now_ms),
        .out_ready (drive.ready),
        .out_valid (drive.valid),
        .out_left  (drive.left_pwm),
        .out_right (drive.right_pwm),
        .out_lost  (drive.line_lost)
    );

endmodule

// File: rtl/lfpd_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on lfpd_pkg for operand widths.
module lfpd_divider
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lfpd_pkg::DVD_W-1:0]    dividend,
    input  logic [lfpd_pkg::TIME_W-1:0]   divisor,
    output logic                          done,
    output logic [lfpd_pkg::DVD_W-1:0]    quotient
);

    localparam int CNT_W = $clog2(lfpd_pkg::DVD_W + 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [lfpd_pkg::TIME_W-1:0]   rem_reg, rem_next;
    logic [lfpd_pkg::DVD_W-1:0]    quo_reg, quo_next;
    logic [lfpd_pkg::TIME_W-1:0]   dsr_reg;
    logic [lfpd_pkg::TIME_W:0]     trial;

    always_comb
    begin
        trial = {rem_reg, quo_reg[lfpd_pkg::DVD_W-1]};
        if (trial >= {1'b0, dsr_reg})
        begin
            rem_next = lfpd_pkg::TIME_W'(trial - {1'b0, dsr_reg});
            quo_next = {quo_reg[lfpd_pkg::DVD_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[lfpd_pkg::TIME_W-1:0];
            quo_next = {quo_reg[lfpd_pkg::DVD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(lfpd_pkg::DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/lfpd_datapath.sv
// Datapath: line position, shared divider and multiplier, PD state, output register.
// Depends on lfpd_pkg and lfpd_divider.
module lfpd_datapath
#(
    parameter int SENSOR_COUNT = 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  lfpd_pkg::cfg_t                  cfg,
    input  lfpd_pkg::cmd_t                  cmd,
    output lfpd_pkg::status_t               status,
    input  logic [lfpd_pkg::SENSOR_W-1:0]   in_bits,
    input  logic [lfpd_pkg::TIME_W-1:0]     in_now,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [lfpd_pkg::PWM_W-1:0]      out_left,
    output logic [lfpd_pkg::PWM_W-1:0]      out_right,
    output logic                            out_lost
);

    localparam int HALF  = SENSOR_COUNT / 2;
    localparam int NUSED = (SENSOR_COUNT < lfpd_pkg::SENSOR_W) ? SENSOR_COUNT
                                                               : lfpd_pkg::SENSOR_W;

    function automatic logic signed [lfpd_pkg::SUM_W-1:0] weight(input int i);
        logic signed [lfpd_pkg::SUM_W-1:0] w;
        if (i < HALF)
        begin
            w = lfpd_pkg::SUM_W'(i - (HALF - 1));
        end
        else
        begin
            w = lfpd_pkg::SUM_W'(i - HALF);
        end
        return w;
    endfunction

    logic [lfpd_pkg::SENSOR_W-1:0]          bits_reg;
    logic [lfpd_pkg::TIME_W-1:0]            now_reg;
    logic [lfpd_pkg::TIME_W-1:0]            last_time_reg;
    logic signed [lfpd_pkg::ERR_W-1:0]      last_error_reg;
    logic signed [lfpd_pkg::ERR_W-1:0]      err_reg;
    logic signed [lfpd_pkg::DER_W-1:0]      deriv_reg;
    logic signed [lfpd_pkg::PROD_W-1:0]     prod_reg;
    logic signed [lfpd_pkg::PROD_W-1:0]     acc_reg;
    logic signed [lfpd_pkg::CORR_W-1:0]     corr_reg;
    logic                                   neg_reg;
    logic                                   out_valid_reg;
    logic [lfpd_pkg::PWM_W-1:0]             left_reg;
    logic [lfpd_pkg::PWM_W-1:0]             right_reg;
    logic                                   lost_reg;

    logic signed [lfpd_pkg::SUM_W-1:0]      sum;
    logic [lfpd_pkg::COUNT_W-1:0]           count;
    logic [lfpd_pkg::SUM_W-1:0]             sum_mag;
    logic [lfpd_pkg::TIME_W-1:0]            dt;
    logic signed [lfpd_pkg::DE_W-1:0]       de;
    logic [lfpd_pkg::DE_W-1:0]              de_mag;
    logic [lfpd_pkg::DVD_W-1:0]             div_dividend;
    logic [lfpd_pkg::TIME_W-1:0]            div_divisor;
    logic                                   div_done;
    logic [lfpd_pkg::DVD_W-1:0]             div_quo;
    logic signed [lfpd_pkg::DER_W-1:0]      quo_s;
    logic signed [lfpd_pkg::GAIN_W:0]       mul_a;
    logic signed [lfpd_pkg::DER_W-1:0]      mul_b;
    logic signed [lfpd_pkg::V_W-1:0]        base16;
    logic signed [lfpd_pkg::V_W-1:0]        corr_x;

    always_comb
    begin
        sum   = '0;
        count = '0;
        for (int i = 0; i < NUSED; i++)
        begin
            if (bits_reg[i])
            begin
                sum   = sum + weight(i);
                count = count + 1'b1;
            end
        end
    end

    assign sum_mag = sum[lfpd_pkg::SUM_W-1] ? lfpd_pkg::SUM_W'(-sum) : sum;
    assign dt      = now_reg - last_time_reg;
    assign de      = lfpd_pkg::DE_W'(err_reg) - lfpd_pkg::DE_W'(last_error_reg);
    assign de_mag  = de[lfpd_pkg::DE_W-1] ? lfpd_pkg::DE_W'(-de) : de;

    always_comb
    begin
        if (cmd.der_start)
        begin
            div_dividend = lfpd_pkg::DVD_W'(de_mag)
                         * lfpd_pkg::DVD_W'(lfpd_pkg::DerivScale);
            div_divisor  = dt;
        end
        else
        begin
            div_dividend = lfpd_pkg::DVD_W'({sum_mag, 8'd0});
            div_divisor  = lfpd_pkg::TIME_W'(count);
        end
    end

    lfpd_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.err_start | cmd.der_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign quo_s = neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

    // One shared multiplier: gain times error, then gain times derivative.
    always_comb
    begin
        if (cmd.mul_p)
        begin
            mul_a = $signed({1'b0, cfg.prop_gain});
            mul_b = lfpd_pkg::DER_W'(err_reg);
        end
        else
        begin
            mul_a = $signed({1'b0, cfg.deriv_gain});
            mul_b = deriv_reg;
        end
    end

    assign base16 = $signed({{(lfpd_pkg::V_W-lfpd_pkg::PWM_W-lfpd_pkg::FRAC_W){1'b0}},
                             cfg.base_speed, {lfpd_pkg::FRAC_W{1'b0}}});
    assign corr_x = lfpd_pkg::V_W'(corr_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bits_reg <= in_bits;
            now_reg  <= in_now;
        end
        if (cmd.err_start)
        begin
            neg_reg <= sum[lfpd_pkg::SUM_W-1];
        end
        else if (cmd.der_start)
        begin
            neg_reg <= de[lfpd_pkg::DE_W-1];
        end
        if (cmd.take_err)
        begin
            err_reg <= quo_s[lfpd_pkg::ERR_W-1:0];
        end
        if (cmd.der_zero)
        begin
            deriv_reg <= '0;
        end
        else if (cmd.take_der)
        begin
            deriv_reg <= quo_s;
        end
        if (cmd.mul_p || cmd.mul_d)
        begin
            prod_reg <= lfpd_pkg::PROD_W'(mul_a * mul_b);
        end
        if (cmd.mul_d)
        begin
            acc_reg <= prod_reg;
        end
        if (cmd.add)
        begin
            corr_reg <= lfpd_pkg::CORR_W'(acc_reg) + lfpd_pkg::CORR_W'(prod_reg);
        end
        if (cmd.out_load)
        begin
            if (count == '0)
            begin
                left_reg  <= cfg.lost_left_pwm;
                right_reg <= cfg.lost_right_pwm;
                lost_reg  <= 1'b1;
            end
            else
            begin
                left_reg  <= lfpd_pkg::duty_of(base16 - corr_x);
                right_reg <= lfpd_pkg::duty_of(base16 + corr_x);
                lost_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            last_error_reg <= '0;
            last_time_reg  <= '0;
        end
        else
        begin
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                if (count != '0)
                begin
                    last_error_reg <= err_reg;
                    last_time_reg  <= now_reg;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.lost     = (count == '0);
    assign status.dt_zero  = (dt == '0);
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_left  = left_reg;
    assign out_right = right_reg;
    assign out_lost  = lost_reg;

endmodule

// File: rtl/lfpd_ctrl.sv
// Per-request sequencer: error divide, derivative divide, PD multiply; all skipped if line lost.
// Depends on lfpd_pkg for the command and status structs.
module lfpd_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lfpd_pkg::status_t   status,
    output lfpd_pkg::cmd_t      cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CHECK  = 9'b000000010,
        S_EDIV   = 9'b000000100,
        S_DSTART = 9'b000001000,
        S_DDIV   = 9'b000010000,
        S_MULP   = 9'b000100000,
        S_MULD   = 9'b001000000,
        S_ADD    = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.lost)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.err_start = 1'b1;
                    state_next    = S_EDIV;
                end
            end
            S_EDIV:
            begin
                if (status.div_done)
                begin
                    cmd.take_err = 1'b1;
                    state_next   = S_DSTART;
                end
            end
            S_DSTART:
            begin
                if (status.dt_zero)
                begin
                    cmd.der_zero = 1'b1;
                    state_next   = S_MULP;
                end
                else
                begin
                    cmd.der_start = 1'b1;
                    state_next    = S_DDIV;
                end
            end
            S_DDIV:
            begin
                if (status.div_done)
                begin
                    cmd.take_der = 1'b1;
                    state_next   = S_MULP;
                end
            end
            S_MULP:
            begin
                cmd.mul_p  = 1'b1;
                state_next = S_MULD;
            end
            S_MULD:
            begin
                cmd.mul_d  = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
